// File: sv/cvrd_pkg.sv
// Shared constants, types and helper functions of the cardiac voxel step core.
// Used by every module in this folder except cvrd_ram; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none
package cvrd_pkg;

    localparam int unsigned VOXELS   = 1024;
    localparam int unsigned VOX_W    = $clog2(VOXELS);
    localparam int unsigned NB_SLOTS = 18;
    localparam int unsigned TN_SLOTS = 9;
    localparam int unsigned WT_SLOTS = 15;
    localparam int unsigned PR_SLOTS = 5;
    localparam int unsigned SLOT_W   = 5;

    localparam int unsigned NB_DEPTH = VOXELS * NB_SLOTS;
    localparam int unsigned TN_DEPTH = VOXELS * TN_SLOTS;
    localparam int unsigned WT_DEPTH = VOXELS * WT_SLOTS;
    localparam int unsigned PR_DEPTH = VOXELS * PR_SLOTS;
    localparam int unsigned VB_DEPTH = 2 * VOXELS;
    localparam int unsigned NB_AW    = $clog2(NB_DEPTH);
    localparam int unsigned TN_AW    = $clog2(TN_DEPTH);
    localparam int unsigned WT_AW    = $clog2(WT_DEPTH);
    localparam int unsigned PR_AW    = $clog2(PR_DEPTH);
    localparam int unsigned VB_AW    = $clog2(VB_DEPTH);

    localparam int unsigned FRAC  = 20;
    localparam int unsigned CFG_W = 31;
    localparam int unsigned CNT_W = VB_AW;

    localparam logic signed [31:0] ONE_Q    = 32'sd1048576;
    localparam logic [CFG_W-1:0]   DT_RESET = 31'd1048;
    localparam logic [CFG_W-1:0]   DS_RESET = 31'd262144;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_SCALE = 2'd1;

    localparam logic [2:0] OP_LD_NB  = 3'd0;
    localparam logic [2:0] OP_LD_TN  = 3'd1;
    localparam logic [2:0] OP_LD_PR  = 3'd2;
    localparam logic [2:0] OP_PREP   = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    localparam int unsigned P_RIN    = 0;
    localparam int unsigned P_ROUT   = 1;
    localparam int unsigned P_ROPEN  = 2;
    localparam int unsigned P_RCLOSE = 3;
    localparam int unsigned P_VGATE  = 4;

    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned RESQ_DEPTH = 2;

    localparam int unsigned PREP_READS = 18;
    localparam int unsigned UPD_READS  = 2 * WT_SLOTS;
    localparam int unsigned MUL_STEPS  = 9;

    localparam logic [4:0] DIAG_A [6] = '{5'd6, 5'd7, 5'd14, 5'd15, 5'd10, 5'd11};
    localparam logic [4:0] DIAG_B [6] = '{5'd8, 5'd9, 5'd16, 5'd17, 5'd12, 5'd13};
    localparam logic [3:0] DIAG_K [6] = '{4'd1, 4'd1, 4'd2, 4'd2, 4'd5, 4'd5};
    localparam logic [3:0] AXIS_K [6] = '{4'd0, 4'd0, 4'd4, 4'd4, 4'd8, 4'd8};
    localparam logic [4:0] PAIR_A [6] = '{5'd6, 5'd9, 5'd14, 5'd17, 5'd10, 5'd13};
    localparam logic [4:0] PAIR_B [6] = '{5'd8, 5'd7, 5'd16, 5'd15, 5'd12, 5'd11};

    typedef enum logic [2:0] {
        K_LD_NB,
        K_LD_TN,
        K_LD_PR,
        K_PREP,
        K_UPDATE
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_GATHER,
        S_FETCH,
        S_PWRITE,
        S_DIFF,
        S_MUL,
        S_WRITE
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [VOX_W-1:0]   voxel;
        logic [SLOT_W-1:0]  slot;
        logic [VOX_W-1:0]   nb;
        logic signed [31:0] value;
        logic               eos;
    } t_cmd;

    typedef struct packed {
        logic [VOX_W-1:0]   voxel;
        logic signed [31:0] voltage;
        logic signed [31:0] gate;
        logic               step_done;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (x < SAT_MIN) begin
            r = -32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] qres(input logic signed [65:0] p);
        return sat32(p >>> FRAC);
    endfunction

    function automatic logic [NB_AW-1:0] nb_addr(input logic [VOX_W-1:0] v,
                                                  input logic [SLOT_W-1:0] s);
        return NB_AW'(v) * NB_AW'(NB_SLOTS) + NB_AW'(s);
    endfunction

    function automatic logic [TN_AW-1:0] tn_addr(input logic [VOX_W-1:0] v,
                                                  input logic [SLOT_W-1:0] s);
        return TN_AW'(v) * TN_AW'(TN_SLOTS) + TN_AW'(s);
    endfunction

    function automatic logic [WT_AW-1:0] wt_addr(input logic [VOX_W-1:0] v,
                                                  input logic [SLOT_W-1:0] s);
        return WT_AW'(v) * WT_AW'(WT_SLOTS) + WT_AW'(s);
    endfunction

    function automatic logic [PR_AW-1:0] pr_addr(input logic [VOX_W-1:0] v,
                                                  input logic [SLOT_W-1:0] s);
        return PR_AW'(v) * PR_AW'(PR_SLOTS) + PR_AW'(s);
    endfunction

    // Cross-sum fetch order: read j covers weight 6+m, neighbour q.
    function automatic logic [1:0] prep_m(input logic [4:0] j);
        logic [1:0] m;
        if (j >= 5'd12) begin
            m = 2'd2;
        end else if (j >= 5'd6) begin
            m = 2'd1;
        end else begin
            m = 2'd0;
        end
        return m;
    endfunction

    function automatic logic [4:0] prep_q(input logic [4:0] j);
        return j - 5'(prep_m(j)) * 5'd6;
    endfunction

    function automatic logic [3:0] prep_k(input logic [4:0] j);
        logic [4:0] q;
        q = prep_q(j);
        return 4'(prep_m(j)) + 4'd3 * 4'(q[2:1]);
    endfunction

    // Update fetch order: two reads per diffusion term, operand a then b.
    function automatic logic [4:0] upd_slot(input logic [4:0] c);
        logic [3:0] i;
        logic [3:0] t;
        logic [4:0] s;
        i = c[4:1];
        t = i - 4'd9;
        if (i < 4'd6) begin
            s = 5'(i);
        end else if (i < 4'd9) begin
            s = {i - 4'd6, c[0]};
        end else begin
            s = c[0] ? PAIR_B[t[2:0]] : PAIR_A[t[2:0]];
        end
        return s;
    endfunction

    function automatic logic [3:0] wt_k(input logic [3:0] s);
        logic [3:0] t;
        logic [3:0] k;
        t = s - 4'd9;
        if (s < 4'd6) begin
            k = AXIS_K[s[2:0]];
        end else if (s >= 4'd9) begin
            k = DIAG_K[t[2:0]];
        end else begin
            k = 4'd0;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// File: sv/cvrd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cvrd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: sv/cvrd_front.sv
// Front end: accepts input items, drops meaningless ones, queues commands.
// Depends on cvrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cvrd_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [2:0]                 i_op,
    input  wire logic [cvrd_pkg::VOX_W-1:0] i_voxel,
    input  wire logic [4:0]                 i_slot,
    input  wire logic [cvrd_pkg::VOX_W-1:0] i_neighbour_index,
    input  wire logic signed [31:0]         i_load_value,
    input  wire logic signed [31:0]         i_stimulus,
    input  wire logic                       i_end_of_step,
    input  wire logic                       i_hold,
    output cvrd_pkg::t_cmd                  o_cmd,
    output logic                            o_cmd_valid,
    input  wire logic                       i_cmd_pop
);
    import cvrd_pkg::*;

    localparam int unsigned QA_W = $clog2(CMDQ_DEPTH);
    localparam int unsigned QC_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd            r_q [CMDQ_DEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;
    t_cmd            w_cmd;
    logic            w_keep;
    logic            w_enq;

    always_comb begin
        w_cmd       = '0;
        w_cmd.voxel = i_voxel;
        w_cmd.slot  = i_slot;
        w_cmd.nb    = (32'(i_neighbour_index) < VOXELS) ? i_neighbour_index : '0;
        w_cmd.value = i_load_value;
        w_cmd.eos   = i_end_of_step;
        w_keep      = 32'(i_voxel) < VOXELS;
        unique case (i_op)
            OP_LD_NB: begin
                w_cmd.kind = K_LD_NB;
                w_keep     = w_keep && (32'(i_slot) < NB_SLOTS);
            end
            OP_LD_TN: begin
                w_cmd.kind = K_LD_TN;
                w_keep     = w_keep && (32'(i_slot) < TN_SLOTS);
            end
            OP_LD_PR: begin
                w_cmd.kind = K_LD_PR;
                w_keep     = w_keep && (32'(i_slot) < PR_SLOTS);
            end
            OP_PREP: begin
                w_cmd.kind = K_PREP;
            end
            OP_UPDATE: begin
                w_cmd.kind  = K_UPDATE;
                w_cmd.value = i_stimulus;
            end
            default: begin
                w_cmd.kind = K_PREP;
                w_keep     = 1'b0;
            end
        endcase
    end

    assign full        = (r_cnt == QC_W'(CMDQ_DEPTH)) || i_hold;
    assign w_enq       = push && !full && w_keep;
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_q[r_rp];
    assign n_cnt       = r_cnt + QC_W'(w_enq) - QC_W'(i_cmd_pop && o_cmd_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= w_cmd;
        end
    end
endmodule
`default_nettype wire

// File: sv/cvrd_resq.sv
// Result queue between the back end and the output handshake.
// Depends on cvrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cvrd_resq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  cvrd_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    input  wire logic        i_pop,
    output cvrd_pkg::t_result o_res
);
    import cvrd_pkg::*;

    localparam int unsigned QA_W = $clog2(RESQ_DEPTH);
    localparam int unsigned QC_W = $clog2(RESQ_DEPTH + 1);

    t_result         r_q [RESQ_DEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QC_W-1:0] r_cnt;
    logic            w_enq, w_deq;

    assign o_full  = r_cnt == QC_W'(RESQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign w_enq   = i_push && !o_full;
    assign w_deq   = i_pop && !o_empty;
    assign o_res   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + QC_W'(w_enq) - QC_W'(w_deq);
            if (w_enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_deq) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wp] <= i_res;
        end
    end
endmodule
`default_nettype wire

// File: sv/cvrd_back.sv
// Back end: sequencer over the voxel memories and one shared multiplier.
// Depends on cvrd_pkg and cvrd_ram.
`timescale 1ns / 1ps
`default_nettype none
module cvrd_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [cvrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cvrd_pkg::CFG_W-1:0]     i_cfg_data,
    input  cvrd_pkg::t_cmd                      i_cmd,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_pop,
    output logic                                o_clearing,
    input  wire logic                           i_res_full,
    output logic                                o_res_push,
    output cvrd_pkg::t_result                   o_res
);
    import cvrd_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    t_cmd               r_cmd;
    logic               r_cur;
    logic [CFG_W-1:0]   r_dt, r_ds;

    logic [VOX_W-1:0]   r_nbr [NB_SLOTS];
    logic signed [31:0] r_d   [TN_SLOTS];
    logic signed [31:0] r_w   [WT_SLOTS];
    logic signed [31:0] r_p   [PR_SLOTS];
    logic signed [32:0] r_dif [WT_SLOTS];
    logic signed [34:0] r_cs  [3];
    logic signed [31:0] r_vc, r_h, r_hold;
    logic signed [65:0] r_prod;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_diff, r_t, r_rate, r_inc, r_g;

    logic               nb_we, tn_we, wt_we, pr_we, vb_we, gs_we;
    logic [NB_AW-1:0]   nb_a;
    logic [TN_AW-1:0]   tn_a;
    logic [WT_AW-1:0]   wt_a;
    logic [PR_AW-1:0]   pr_a;
    logic [VB_AW-1:0]   vb_a;
    logic [VOX_W-1:0]   gs_a;
    logic [VOX_W-1:0]   nb_wd, nb_rd;
    logic [31:0]        tn_wd, tn_rd, wt_wd, wt_rd, pr_wd, pr_rd, vb_wd, vb_rd, gs_wd, gs_rd;

    logic [4:0]         c5, w_idx;
    logic [3:0]         c4, w_step, w_term;
    logic [NB_SLOTS-1:0] w_pres;
    logic [2:0]         w_pair;
    logic [WT_SLOTS-1:0] w_cond;
    logic signed [31:0] w_weight;
    logic signed [32:0] w_ma, w_mb;
    logic signed [31:0] w_q, w_nv, w_nh;
    logic [1:0]         w_m;
    logic [1:0]         w_p;
    logic               w_last;
    logic               w_is_prep;

    assign c5        = r_cnt[4:0];
    assign c4        = r_cnt[3:0];
    assign w_idx     = r_cnt[4:0] - 5'd1;
    assign w_step    = r_cnt[4:1];
    assign w_term    = w_idx[4:1];
    assign w_is_prep = r_cmd.kind == K_PREP;
    assign w_m       = prep_m(w_idx);
    assign w_p       = 2'(prep_q(w_idx) >> 1);

    cvrd_ram #(.WIDTH(VOX_W), .DEPTH(NB_DEPTH)) u_nb_ram (
        .i_clk(i_clk), .i_we(nb_we), .i_addr(nb_a), .i_wdata(nb_wd), .o_rdata(nb_rd));
    cvrd_ram #(.WIDTH(32), .DEPTH(TN_DEPTH)) u_tn_ram (
        .i_clk(i_clk), .i_we(tn_we), .i_addr(tn_a), .i_wdata(tn_wd), .o_rdata(tn_rd));
    cvrd_ram #(.WIDTH(32), .DEPTH(WT_DEPTH)) u_wt_ram (
        .i_clk(i_clk), .i_we(wt_we), .i_addr(wt_a), .i_wdata(wt_wd), .o_rdata(wt_rd));
    cvrd_ram #(.WIDTH(32), .DEPTH(PR_DEPTH)) u_pr_ram (
        .i_clk(i_clk), .i_we(pr_we), .i_addr(pr_a), .i_wdata(pr_wd), .o_rdata(pr_rd));
    cvrd_ram #(.WIDTH(32), .DEPTH(VB_DEPTH)) u_vb_ram (
        .i_clk(i_clk), .i_we(vb_we), .i_addr(vb_a), .i_wdata(vb_wd), .o_rdata(vb_rd));
    cvrd_ram #(.WIDTH(32), .DEPTH(VOXELS)) u_gs_ram (
        .i_clk(i_clk), .i_we(gs_we), .i_addr(gs_a), .i_wdata(gs_wd), .o_rdata(gs_rd));

    // presence and weight conditions
    always_comb begin
        for (int i = 0; i < NB_SLOTS; i++) begin
            w_pres[i] = r_nbr[i] != '0;
        end
        for (int i = 0; i < 3; i++) begin
            w_pair[i] = w_pres[2 * i] && w_pres[2 * i + 1];
        end
        for (int i = 0; i < 6; i++) begin
            w_cond[i]     = w_pres[i];
            w_cond[9 + i] = w_pres[DIAG_A[i]] && w_pres[DIAG_B[i]];
        end
        for (int i = 0; i < 3; i++) begin
            w_cond[6 + i] = w_pair[i];
        end
    end

    always_comb begin
        w_weight = '0;
        if (!w_cond[c4]) begin
            w_weight = '0;
        end else if (c4 < 4'd6) begin
            w_weight = sat32(66'(r_d[wt_k(c4)]) * 66'sd4);
        end else if (c4 < 4'd9) begin
            w_weight = sat32(66'(r_cs[2'(c4 - 4'd6)]));
        end else begin
            w_weight = sat32(66'(r_d[wt_k(c4)]) * 66'sd2);
        end
    end

    // multiplier operands
    always_comb begin
        w_ma = 33'(r_dif[c4]);
        w_mb = 33'(r_w[c4]);
        if (r_state == S_MUL) begin
            unique case (w_step)
                4'd0: begin
                    w_ma = 33'(sat32(66'(r_acc)));
                    w_mb = $signed({2'b00, r_ds});
                end
                4'd1: begin
                    w_ma = 33'(r_vc);
                    w_mb = 33'(r_vc);
                end
                4'd2: begin
                    w_ma = 33'(r_h);
                    w_mb = 33'(r_t);
                end
                4'd3: begin
                    w_ma = 33'(r_t);
                    w_mb = 33'(ONE_Q) - 33'(r_vc);
                end
                4'd4: begin
                    w_ma = 33'(r_t);
                    w_mb = 33'(r_p[P_RIN]);
                end
                4'd5: begin
                    w_ma = -33'(r_vc);
                    w_mb = 33'(r_p[P_ROUT]);
                end
                4'd6: begin
                    w_ma = 33'(r_rate);
                    w_mb = $signed({2'b00, r_dt});
                end
                4'd7: begin
                    if (r_vc < r_p[P_VGATE]) begin
                        w_ma = 33'(ONE_Q) - 33'(r_h);
                        w_mb = 33'(r_p[P_ROPEN]);
                    end else begin
                        w_ma = -33'(r_h);
                        w_mb = 33'(r_p[P_RCLOSE]);
                    end
                end
                default: begin
                    w_ma = 33'(r_t);
                    w_mb = $signed({2'b00, r_dt});
                end
            endcase
        end
    end

    assign w_q  = qres(r_prod);
    assign w_nv = sat32(66'(r_vc) + 66'(r_inc));
    assign w_nh = sat32(66'(r_h) + 66'(r_g));

    // memory ports
    always_comb begin
        nb_we = 1'b0; tn_we = 1'b0; wt_we = 1'b0; pr_we = 1'b0; vb_we = 1'b0; gs_we = 1'b0;
        nb_a  = '0;   tn_a  = '0;   wt_a  = '0;   pr_a  = '0;   vb_a  = '0;   gs_a  = '0;
        nb_wd = r_cmd.nb;
        tn_wd = r_cmd.value;
        pr_wd = r_cmd.value;
        wt_wd = w_weight;
        vb_wd = w_nv;
        gs_wd = w_nh;
        unique case (r_state)
            S_CLEAR: begin
                vb_we = 1'b1;
                vb_a  = r_cnt[VB_AW-1:0];
                vb_wd = '0;
                gs_we = !r_cnt[VB_AW-1];
                gs_a  = r_cnt[VOX_W-1:0];
                gs_wd = ONE_Q;
            end
            S_LOAD: begin
                nb_we = r_cmd.kind == K_LD_NB;
                tn_we = r_cmd.kind == K_LD_TN;
                pr_we = r_cmd.kind == K_LD_PR;
                nb_a  = nb_addr(r_cmd.voxel, r_cmd.slot);
                tn_a  = tn_addr(r_cmd.voxel, r_cmd.slot);
                pr_a  = pr_addr(r_cmd.voxel, r_cmd.slot);
            end
            S_GATHER: begin
                nb_a = nb_addr(r_cmd.voxel, (32'(c5) < NB_SLOTS) ? c5 : '0);
                tn_a = tn_addr(r_cmd.voxel, (32'(c5) < TN_SLOTS) ? c5 : '0);
                wt_a = wt_addr(r_cmd.voxel, (32'(c5) < WT_SLOTS) ? c5 : '0);
                pr_a = pr_addr(r_cmd.voxel, (32'(c5) < PR_SLOTS) ? c5 : '0);
                vb_a = {r_cur, r_cmd.voxel};
                gs_a = r_cmd.voxel;
            end
            S_FETCH: begin
                tn_a = tn_addr(r_nbr[(32'(c5) < PREP_READS) ? prep_q(c5) : '0],
                               5'(prep_k((32'(c5) < PREP_READS) ? c5 : '0)));
                vb_a = {r_cur, r_nbr[(32'(c5) < UPD_READS) ? upd_slot(c5) : '0]};
            end
            S_PWRITE: begin
                wt_we = 1'b1;
                wt_a  = wt_addr(r_cmd.voxel, c5);
            end
            S_WRITE: begin
                vb_we = !i_res_full;
                vb_a  = {!r_cur, r_cmd.voxel};
                gs_we = !i_res_full;
                gs_a  = r_cmd.voxel;
            end
            default: begin
                nb_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        w_last  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_cnt == CNT_W'(VB_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.kind == K_PREP || i_cmd.kind == K_UPDATE)
                              ? S_GATHER : S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            S_GATHER: begin
                if (r_cnt == CNT_W'(NB_SLOTS)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                w_last = w_is_prep ? (r_cnt == CNT_W'(PREP_READS))
                                   : (r_cnt == CNT_W'(UPD_READS));
                if (w_last) begin
                    n_state = w_is_prep ? S_PWRITE : S_DIFF;
                end
            end
            S_PWRITE: begin
                if (r_cnt == CNT_W'(WT_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_DIFF: begin
                if (r_cnt == CNT_W'(WT_SLOTS)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(2 * MUL_STEPS - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop           = (r_state == S_IDLE) && i_cmd_valid;
        o_clearing          = r_state == S_CLEAR;
        o_res_push          = (r_state == S_WRITE) && !i_res_full;
        o_res.voxel         = r_cmd.voxel;
        o_res.voltage       = w_nv;
        o_res.gate          = w_nh;
        o_res.step_done     = r_cmd.eos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_cur   <= 1'b0;
            r_dt    <= DT_RESET;
            r_ds    <= DS_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state != n_state) ? '0 : r_cnt + 1'b1;
            if (o_res_push && r_cmd.eos) begin
                r_cur <= !r_cur;
            end
            if (i_cfg_valid && i_cfg_index == CFG_TIME_STEP) begin
                r_dt <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_DIFF_SCALE) begin
                r_ds <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        unique case (r_state)
            S_GATHER: begin
                for (int i = 0; i < 3; i++) begin
                    r_cs[i] <= '0;
                end
                if (r_cnt != '0) begin
                    r_nbr[w_idx] <= nb_rd;
                    if (32'(w_idx) < TN_SLOTS) begin
                        r_d[w_idx[3:0]] <= tn_rd;
                    end
                    if (32'(w_idx) < WT_SLOTS) begin
                        r_w[w_idx[3:0]] <= wt_rd;
                    end
                    if (32'(w_idx) < PR_SLOTS) begin
                        r_p[w_idx[2:0]] <= pr_rd;
                    end
                    if (w_idx == '0) begin
                        r_vc <= vb_rd;
                        r_h  <= gs_rd;
                    end
                end
            end
            S_FETCH: begin
                r_acc <= '0;
                if (r_cnt != '0) begin
                    if (w_is_prep) begin
                        if (!w_idx[0]) begin
                            r_hold <= tn_rd;
                        end else if (w_pair[w_p]) begin
                            r_cs[w_m] <= r_cs[w_m] + 35'(r_hold) - 35'($signed(tn_rd));
                        end
                    end else begin
                        if (!w_idx[0]) begin
                            r_hold <= vb_rd;
                            if (w_term < 4'd6) begin
                                r_dif[w_term] <= 33'($signed(vb_rd)) - 33'(r_vc);
                            end
                        end else if (w_term >= 4'd6) begin
                            r_dif[w_term] <= 33'(r_hold) - 33'($signed(vb_rd));
                        end
                    end
                end
            end
            S_DIFF: begin
                if (32'(r_cnt) < WT_SLOTS) begin
                    r_prod <= w_ma * w_mb;
                end
                if (r_cnt != '0) begin
                    r_acc <= r_acc + 50'(r_prod >>> FRAC);
                end
            end
            S_MUL: begin
                if (!r_cnt[0]) begin
                    r_prod <= w_ma * w_mb;
                end else begin
                    unique case (w_step)
                        4'd0: r_diff <= w_q;
                        4'd5: r_rate <= sat32(66'(r_t) + 66'(w_q) + 66'(r_cmd.value)
                                              + 66'(r_diff));
                        4'd6: r_inc  <= w_q;
                        4'd8: r_g    <= w_q;
                        default: r_t <= w_q;
                    endcase
                end
            end
            default: begin
                r_hold <= r_hold;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: sv/cardiac_voxel_reaction_diffusion_step_core.sv
// Update item: command pop, gather, fetch, diffusion, cell, write; prepare item: pop,
// gather, fetch, weight write; load items: pop, write; one item at a time. The
// single-port voxel memories and the one shared 33x33 multiplier set this sequence.
// Reset is synchronous, active low; afterwards a clearing pass over all 2048 voltage
// entries sets voltages to zero and gates to one while full stays high. Config writes
// are always taken. Depends on cvrd_pkg, cvrd_front, cvrd_back, cvrd_resq, cvrd_ram.
`timescale 1ns / 1ps
`default_nettype none
module cardiac_voxel_reaction_diffusion_step_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [2:0]                     i_op,
    input  wire logic [cvrd_pkg::VOX_W-1:0]     i_voxel,
    input  wire logic [4:0]                     i_slot,
    input  wire logic [cvrd_pkg::VOX_W-1:0]     i_neighbour_index,
    input  wire logic signed [31:0]             i_load_value,
    input  wire logic signed [31:0]             i_stimulus,
    input  wire logic                           i_end_of_step,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [cvrd_pkg::VOX_W-1:0]          o_out_voxel,
    output logic signed [31:0]                  o_voltage,
    output logic signed [31:0]                  o_gate,
    output logic                                o_step_done,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cvrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cvrd_pkg::CFG_W-1:0]     i_cfg_data
);
    import cvrd_pkg::*;

    t_cmd    w_cmd;
    logic    w_cmd_valid, w_cmd_pop, w_clearing;
    logic    w_res_full, w_res_push;
    t_result w_res, w_out;

    assign o_cfg_ready = 1'b1;

    cvrd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_op(i_op), .i_voxel(i_voxel), .i_slot(i_slot),
        .i_neighbour_index(i_neighbour_index), .i_load_value(i_load_value),
        .i_stimulus(i_stimulus), .i_end_of_step(i_end_of_step),
        .i_hold(w_clearing), .o_cmd(w_cmd), .o_cmd_valid(w_cmd_valid),
        .i_cmd_pop(w_cmd_pop));

    cvrd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_cmd(w_cmd), .i_cmd_valid(w_cmd_valid), .o_cmd_pop(w_cmd_pop),
        .o_clearing(w_clearing), .i_res_full(w_res_full),
        .o_res_push(w_res_push), .o_res(w_res));

    cvrd_resq u_resq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_res_push), .i_res(w_res),
        .o_full(w_res_full), .o_empty(empty), .i_pop(pop), .o_res(w_out));

    assign o_out_voxel = w_out.voxel;
    assign o_voltage   = w_out.voltage;
    assign o_gate      = w_out.gate;
    assign o_step_done = w_out.step_done;

`ifndef SYNTH
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> full)
        else $error("input open during clearing pass");
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid && !w_clearing)
        else $error("command taken from empty queue");
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into full queue");
`endif
endmodule
`default_nettype wire
